// ----- rtl/lru_pkg.sv -----
package lru_pkg;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch the page and clear the search trackers
    logic scan;    // read the frame at the scan index and advance it
    logic update;  // commit the replacement decision and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the scan index points at the last frame
  } sts_t;

  localparam int unsigned SlotOutBits = 2;
  localparam int unsigned PageOutBits = 8;
  localparam int unsigned CountBits   = 32;

endpackage

// ----- rtl/lru_page_replacement.sv -----
// LRU page replacement over FRAMES fully associative frames. A request is
// taken when start is high and busy is low; its result appears on the
// result ports for exactly one cycle, marked by result_valid_o, and must be
// captured then, since the receiver cannot stall the block. While a request
// is busy, the frame page store is read one frame per cycle through its
// single read port, a finish state completes the last compare and an update
// state commits the replacement. The strobe follows in the next cycle,
// during which busy is already low, so a new request can be taken while the
// strobe is shown. The hit and fault totals saturate at their maximum.
module lru_page_replacement #(
  parameter int unsigned FRAMES    = 4,
  parameter int unsigned PAGE_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [lru_pkg::PageOutBits-1:0] page_number_i,
  output logic                            result_valid_o,
  output logic                            hit_o,
  output logic [lru_pkg::SlotOutBits-1:0] slot_o,
  output logic                            evicted_valid_o,
  output logic [lru_pkg::PageOutBits-1:0] evicted_page_o,
  output logic [lru_pkg::CountBits-1:0]   hit_total_o,
  output logic [lru_pkg::CountBits-1:0]   fault_total_o
);

  lru_pkg::cmd_t cmd;
  lru_pkg::sts_t sts;

  // Sequencer.
  lru_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Frame store, search and recency logic.
  lru_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .page_number_i   (page_number_i),
    .result_valid_o  (result_valid_o),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .hit_total_o     (hit_total_o),
    .fault_total_o   (fault_total_o)
  );

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request");

  // Every commit produces exactly one result strobe in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |=> (result_valid_o && !busy))
    else $error("commit was not followed by a result strobe");

  // A hit never reports an eviction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> (!evicted_valid_o && (evicted_page_o == '0)))
    else $error("hit reported an evicted page");

  // The scan and commit commands never overlap a new request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan || cmd.update) |-> !cmd.start)
    else $error("request started while a previous one was in progress");

endmodule

// ----- rtl/lru_ctrl.sv -----
module lru_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lru_pkg::sts_t sts_i,
  output lru_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  lru_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lru_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    busy_o       = 1'b1;
    unique case (state_q)
      lru_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.start = 1'b1;
          state_d     = lru_pkg::ST_SCAN;
        end
      end
      lru_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = lru_pkg::ST_FINISH;
        end
      end
      lru_pkg::ST_FINISH: begin
        // The last frame read is compared in this cycle.
        state_d = lru_pkg::ST_UPDATE;
      end
      lru_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = lru_pkg::ST_IDLE;
      end
      default: begin
        state_d = lru_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lru_dp.sv -----
module lru_dp #(
  parameter int unsigned FRAMES    = 4,
  parameter int unsigned PAGE_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lru_pkg::cmd_t                     cmd_i,
  output lru_pkg::sts_t                     sts_o,
  input  logic [lru_pkg::PageOutBits-1:0]   page_number_i,
  output logic                              result_valid_o,
  output logic                              hit_o,
  output logic [lru_pkg::SlotOutBits-1:0]   slot_o,
  output logic                              evicted_valid_o,
  output logic [lru_pkg::PageOutBits-1:0]   evicted_page_o,
  output logic [lru_pkg::CountBits-1:0]     hit_total_o,
  output logic [lru_pkg::CountBits-1:0]     fault_total_o
);

  localparam int unsigned IdxW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned OutW  = lru_pkg::PageOutBits;
  localparam int unsigned SlotW = lru_pkg::SlotOutBits;
  localparam int unsigned CntW  = lru_pkg::CountBits;

  // Frame contents, valid bits and age ranks (0 is the most recent).
  logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
  logic [FRAMES-1:0]    valid_q, valid_d;
  logic [RankW-1:0]     rank_q [FRAMES];
  logic [RankW-1:0]     rank_d [FRAMES];

  // Request page, scan pointer and the registered frame read.
  logic [PAGE_BITS-1:0] page_q;
  logic [PAGE_BITS-1:0] page_in;
  logic [PAGE_BITS+OutW-1:0] page_ext;
  logic [IdxW-1:0]      idx_q;
  logic [IdxW-1:0]      cmp_idx_q;
  logic                 cmp_en_q;
  logic [PAGE_BITS-1:0] rd_q;

  // Search trackers.
  logic                 found_q;
  logic [IdxW-1:0]      hit_slot_q;
  logic [RankW-1:0]     hit_rank_q;
  logic                 empty_q;
  logic [IdxW-1:0]      empty_slot_q;
  logic [IdxW-1:0]      old_slot_q;
  logic [RankW-1:0]     old_rank_q;
  logic [PAGE_BITS-1:0] old_page_q;

  // Replacement decision.
  logic [IdxW-1:0]      slot;
  logic [RankW-1:0]     limit;
  logic                 age_all;
  logic                 evict;
  logic [PAGE_BITS+OutW-1:0] ev_ext;
  logic [IdxW+SlotW-1:0]     slot_ext;

  // Counters and result registers.
  logic [CntW-1:0]      hit_cnt_q, fault_cnt_q;
  logic                 res_vld_q;
  logic                 res_hit_q;
  logic [SlotW-1:0]     res_slot_q;
  logic                 res_ev_vld_q;
  logic [OutW-1:0]      res_ev_page_q;

  // Only the low PAGE_BITS bits of the request take part.
  assign page_ext = {{PAGE_BITS{1'b0}}, page_number_i};
  assign page_in  = page_ext[PAGE_BITS-1:0];

  assign sts_o.scan_last = (idx_q == IdxW'(FRAMES - 1));

  // Scan pointer and compare-stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      cmp_en_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.scan;
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Frame page store: one read for the scan, one write on a fault.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rd_q <= frame_page_q[idx_q];
    end
    if (cmd_i.update && !found_q) begin
      frame_page_q[slot] <= page_q;
    end
  end

  // Compare stage: first hit, first empty frame, oldest frame.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      cmp_idx_q <= idx_q;
    end
    if (cmd_i.start) begin
      page_q  <= page_in;
      found_q <= 1'b0;
      empty_q <= 1'b0;
    end else if (cmp_en_q) begin
      if (!found_q && valid_q[cmp_idx_q] && (rd_q == page_q)) begin
        found_q    <= 1'b1;
        hit_slot_q <= cmp_idx_q;
        hit_rank_q <= rank_q[cmp_idx_q];
      end
      if (!empty_q && !valid_q[cmp_idx_q]) begin
        empty_q      <= 1'b1;
        empty_slot_q <= cmp_idx_q;
      end
      if ((cmp_idx_q == '0) || (rank_q[cmp_idx_q] > old_rank_q)) begin
        old_slot_q <= cmp_idx_q;
        old_rank_q <= rank_q[cmp_idx_q];
        old_page_q <= rd_q;
      end
    end
  end

  // Pick the frame to use and how far the recency update reaches.
  always_comb begin
    age_all = 1'b0;
    evict   = 1'b0;
    priority if (found_q) begin
      slot  = hit_slot_q;
      limit = hit_rank_q;
    end else if (empty_q) begin
      slot    = empty_slot_q;
      limit   = hit_rank_q;
      age_all = 1'b1;
    end else begin
      slot  = old_slot_q;
      limit = old_rank_q;
      evict = 1'b1;
    end
  end

  // Recency update: the used frame becomes the youngest, younger ones age.
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < FRAMES; i++) begin
      rank_d[i] = rank_q[i];
      if (IdxW'(i) == slot) begin
        rank_d[i]  = '0;
        valid_d[i] = 1'b1;
      end else if (valid_q[i] && (age_all || (rank_q[i] < limit))) begin
        rank_d[i] = rank_q[i] + RankW'(1);
      end
    end
  end

  // Frame state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      valid_q <= valid_d;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= rank_d[i];
      end
      if (found_q) begin
        if (hit_cnt_q != '1) begin
          hit_cnt_q <= hit_cnt_q + CntW'(1);
        end
      end else if (fault_cnt_q != '1) begin
        fault_cnt_q <= fault_cnt_q + CntW'(1);
      end
    end
  end

  assign ev_ext   = {{OutW{1'b0}}, old_page_q};
  assign slot_ext = {{SlotW{1'b0}}, slot};

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.update;
    end
  end

  // Result fields, held until the next request completes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      res_hit_q     <= found_q;
      res_slot_q    <= slot_ext[SlotW-1:0];
      res_ev_vld_q  <= evict;
      res_ev_page_q <= evict ? ev_ext[OutW-1:0] : '0;
    end
  end

  assign result_valid_o  = res_vld_q;
  assign hit_o           = res_hit_q;
  assign slot_o          = res_slot_q;
  assign evicted_valid_o = res_ev_vld_q;
  assign evicted_page_o  = res_ev_page_q;
  assign hit_total_o     = hit_cnt_q;
  assign fault_total_o   = fault_cnt_q;

endmodule

// ----- sim/tb_lru_page_replacement.sv -----
module tb_lru_page_replacement;

  localparam int unsigned FRAMES     = 4;
  localparam int unsigned PAGE_BITS  = 8;
  localparam int unsigned RAND_REFS  = 600;
  localparam int unsigned DIR_ROWS   = 22;
  localparam int unsigned DRAIN_WAIT = 3 * (FRAMES + 3);
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned SlotW      = lru_pkg::SlotOutBits;
  localparam int unsigned PageW      = lru_pkg::PageOutBits;
  localparam int unsigned CntW       = lru_pkg::CountBits;

  // One result of a page reference, at the widths of the result ports.
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
    logic             ev_valid;
    logic [PageW-1:0] ev_page;
    logic [CntW-1:0]  hits;
    logic [CntW-1:0]  faults;
  } page_result_t;

  // A row of the directed sequence; the result is given only where typed is set.
  typedef struct packed {
    logic [PageW-1:0] page;
    logic             typed;
    page_result_t     want;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [PageW-1:0] page_number_i;
  logic             result_valid_o;
  logic             hit_o;
  logic [SlotW-1:0] slot_o;
  logic             evicted_valid_o;
  logic [PageW-1:0] evicted_page_o;
  logic [CntW-1:0]  hit_total_o;
  logic [CntW-1:0]  fault_total_o;

  lru_page_replacement #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .page_number_i  (page_number_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .hit_total_o    (hit_total_o),
    .fault_total_o  (fault_total_o)
  );

  // Shadow copy of the frame set used to predict each result.
  logic [PageW-1:0] shadow_page [FRAMES];
  logic             shadow_valid [FRAMES];
  int unsigned      shadow_rank [FRAMES];
  logic [CntW-1:0]  shadow_hits;
  logic [CntW-1:0]  shadow_faults;

  page_result_t pending_results[$];
  int unsigned  error_count;
  int unsigned  request_count;
  int unsigned  result_count;
  int unsigned  hit_seen;
  int unsigned  evict_seen;
  int unsigned  cycle_count;
  int unsigned  burst_left;

  // Working set of pages for the random references.
  logic [PageW-1:0] page_pool [8];

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Ages the valid frames younger than limit and makes frame f the newest.
  task automatic shadow_touch(input int unsigned f, input int unsigned limit);
    for (int unsigned i = 0; i < FRAMES; i++) begin
      if (i != f && shadow_valid[i] && shadow_rank[i] < limit) begin
        shadow_rank[i] = shadow_rank[i] + 1;
      end
    end
    shadow_rank[f] = 0;
  endtask

  // Looks the page up in the shadow frames, updates them and returns the result.
  task automatic predict_lookup(input logic [PageW-1:0] pg, output page_result_t res);
    int unsigned slot;
    int unsigned oldest;
    bit          found;
    bit          has_empty;
    slot      = 0;
    found     = 1'b0;
    has_empty = 1'b0;
    res       = '0;
    for (int unsigned i = 0; i < FRAMES; i++) begin
      if (!found && shadow_valid[i] && shadow_page[i] == pg) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      shadow_touch(slot, shadow_rank[slot]);
      if (shadow_hits != '1) shadow_hits = shadow_hits + 1;
    end else begin
      for (int unsigned i = 0; i < FRAMES; i++) begin
        if (!has_empty && !shadow_valid[i]) begin
          has_empty = 1'b1;
          slot      = i;
        end
      end
      if (has_empty) begin
        shadow_touch(slot, 32'hFF);
      end else begin
        oldest = 0;
        for (int unsigned i = 1; i < FRAMES; i++) begin
          if (shadow_rank[i] > shadow_rank[oldest]) oldest = i;
        end
        slot         = oldest;
        res.ev_valid = 1'b1;
        res.ev_page  = shadow_page[slot];
        shadow_touch(slot, shadow_rank[slot]);
      end
      shadow_page[slot]  = pg;
      shadow_valid[slot] = 1'b1;
      if (shadow_faults != '1) shadow_faults = shadow_faults + 1;
    end
    res.hit    = found;
    res.slot   = slot[SlotW-1:0];
    res.hits   = shadow_hits;
    res.faults = shadow_faults;
  endtask

  // Directed references: page extremes, fills, hits at every age, and evictions.
  function automatic dir_row_t dir_row(input int unsigned idx);
    case (idx)
      0:  dir_row = '{8'h00, 1'b1, '{1'b0, 2'd0, 1'b0, 8'h00, 32'd0, 32'd1}};
      1:  dir_row = '{8'hFF, 1'b1, '{1'b0, 2'd1, 1'b0, 8'h00, 32'd0, 32'd2}};
      2:  dir_row = '{8'h55, 1'b1, '{1'b0, 2'd2, 1'b0, 8'h00, 32'd0, 32'd3}};
      3:  dir_row = '{8'hAA, 1'b1, '{1'b0, 2'd3, 1'b0, 8'h00, 32'd0, 32'd4}};
      4:  dir_row = '{8'h00, 1'b1, '{1'b1, 2'd0, 1'b0, 8'h00, 32'd1, 32'd4}};
      5:  dir_row = '{8'h01, 1'b1, '{1'b0, 2'd1, 1'b1, 8'hFF, 32'd1, 32'd5}};
      6:  dir_row = '{8'h01, 1'b0, '0};
      7:  dir_row = '{8'hFF, 1'b0, '0};
      8:  dir_row = '{8'h80, 1'b0, '0};
      9:  dir_row = '{8'h7F, 1'b0, '0};
      10: dir_row = '{8'h7F, 1'b0, '0};
      11: dir_row = '{8'h80, 1'b0, '0};
      12: dir_row = '{8'hFF, 1'b0, '0};
      13: dir_row = '{8'h01, 1'b0, '0};
      14: dir_row = '{8'h00, 1'b0, '0};
      15: dir_row = '{8'hFE, 1'b0, '0};
      16: dir_row = '{8'h02, 1'b0, '0};
      17: dir_row = '{8'h03, 1'b0, '0};
      18: dir_row = '{8'h04, 1'b0, '0};
      19: dir_row = '{8'hFE, 1'b0, '0};
      20: dir_row = '{8'h00, 1'b0, '0};
      default: dir_row = '{8'h55, 1'b0, '0};
    endcase
  endfunction

  // Issues one request, with a random idle gap at the start of each burst.
  task automatic issue_request(input logic [PageW-1:0] pg, output bit accepted);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start         <= 1'b1;
    page_number_i <= pg;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    accepted = 1'b1;
  endtask

  function automatic logic [PageW-1:0] pick_page();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      pick_page = page_pool[$urandom_range(0, 4)];
    end else if (sel < 85) begin
      pick_page = page_pool[$urandom_range(0, 7)];
    end else begin
      pick_page = PageW'($urandom_range(0, 255));
    end
  endfunction

  // Stimulus: reset, directed rows, then random references.
  initial begin
    dir_row_t     row;
    page_result_t res;
    bit           accepted;
    rst_ni        = 1'b0;
    start         = 1'b0;
    page_number_i = '0;
    error_count   = 0;
    request_count = 0;
    result_count  = 0;
    hit_seen      = 0;
    evict_seen    = 0;
    burst_left    = 0;
    shadow_hits   = '0;
    shadow_faults = '0;
    for (int unsigned i = 0; i < FRAMES; i++) begin
      shadow_page[i]  = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 0;
    end
    for (int unsigned i = 0; i < 8; i++) begin
      page_pool[i] = PageW'($urandom_range(0, 255));
    end
    page_pool[0] = 8'h00;
    page_pool[1] = 8'hFF;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < DIR_ROWS; r++) begin
      row = dir_row(r);
      issue_request(row.page, accepted);
      predict_lookup(row.page, res);
      pending_results.push_back(row.typed ? row.want : res);
      request_count++;
    end

    for (int unsigned n = 0; n < RAND_REFS; n++) begin
      // Now and then the working set drifts so older pages fall out.
      if ($urandom_range(0, 19) == 0) begin
        page_pool[$urandom_range(0, 7)] = PageW'($urandom_range(0, 255));
      end
      row.page = pick_page();
      issue_request(row.page, accepted);
      predict_lookup(row.page, res);
      pending_results.push_back(res);
      request_count++;
    end
    start <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Issued %0d page references; checked %0d results with %0d hits and %0d evictions.",
             request_count, result_count, hit_seen, evict_seen);
    if (error_count == 0) begin
      $display("lru_page_replacement verification clean");
    end else begin
      $display("lru_page_replacement verification failed");
    end
    $finish;
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Each strobed result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual hit=%0b slot=%0d", $time,
                 hit_o, slot_o);
      end else begin
        want = pending_results.pop_front();
        result_count++;
        if (want.hit) hit_seen++;
        if (want.ev_valid) evict_seen++;
        check_field("hit", 32'(want.hit), 32'(hit_o));
        check_field("slot", 32'(want.slot), 32'(slot_o));
        check_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid_o));
        check_field("evicted_page", 32'(want.ev_page), 32'(evicted_page_o));
        check_field("hit_total", want.hits, hit_total_o);
        check_field("fault_total", want.faults, fault_total_o);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_CAP);
      $display("lru_page_replacement verification failed");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

// ----- filelist.f -----
rtl/lru_pkg.sv
rtl/lru_ctrl.sv
rtl/lru_dp.sv
rtl/lru_page_replacement.sv
sim/tb_lru_page_replacement.sv
